// File: hdl/epp_pkg.sv
// Shared widths, constants and the arctangent table for the ellipse point projector.
package epp_pkg;

  // CORDIC depth; entries of the arctangent table from index CORDIC_STAGES on are never run
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int RUN_STAGES    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

  // Angle accumulator (Q30 radians with headroom) and CORDIC vector width
  localparam int ZW = 34;
  localparam int XW = 35;
  // Scaled point width (Q16)
  localparam int PW = 36;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic [29:0]          KINV_Q30    = 30'd652032874;

  localparam logic signed [31:0] OUT_MAX = 32'sd8388607;
  localparam logic signed [31:0] OUT_MIN = -32'sd8388608;

  typedef enum logic [2:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_FULL_WIDTH  = 3'd2,
    REG_FULL_HEIGHT = 3'd3,
    REG_ROT_COS     = 3'd4,
    REG_ROT_SIN     = 3'd5
  } reg_idx_t;

  // Folded angle and start vector leaving the front end
  typedef struct packed {
    logic                 flip;
    logic signed [ZW-1:0] z;
    logic signed [XW-1:0] x;
  } front_t;

  // Rotated vector leaving the CORDIC
  typedef struct packed {
    logic                 flip;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
  } cord_t;

  // Scaled point leaving the axis scaler
  typedef struct packed {
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
  } point_t;

  // floor(atan(2^-i) * 2^30)
  function automatic logic [29:0] atan_q30(input int idx);
    logic [29:0] t;
    case (idx)
      0:  t = 30'd843314856;
      1:  t = 30'd497837829;
      2:  t = 30'd263043836;
      3:  t = 30'd133525158;
      4:  t = 30'd67021686;
      5:  t = 30'd33543515;
      6:  t = 30'd16775850;
      7:  t = 30'd8388437;
      8:  t = 30'd4194282;
      9:  t = 30'd2097149;
      10: t = 30'd1048575;
      11: t = 30'd524287;
      12: t = 30'd262143;
      13: t = 30'd131071;
      14: t = 30'd65535;
      15: t = 30'd32767;
      16: t = 30'd16383;
      17: t = 30'd8191;
      18: t = 30'd4095;
      19: t = 30'd2047;
      20: t = 30'd1023;
      21: t = 30'd511;
      22: t = 30'd255;
      23: t = 30'd127;
      default: t = 30'd0;
    endcase
    return t;
  endfunction

endpackage

// File: hdl/epp_front.sv
// Front end: fold the angle into the CORDIC range and form the gain-corrected start radius.
module epp_front import epp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [15:0] polar_angle,
  input  logic [15:0]        polar_radius,
  output logic               out_valid,
  output front_t             out_beat
);

  logic signed [ZW-1:0] z_raw;
  logic [45:0]          gain_prod;
  front_t               beat_next;

  always_comb begin
    z_raw     = {{(ZW-33){polar_angle[15]}}, polar_angle, 17'b0};
    gain_prod = 46'(polar_radius) * 46'(KINV_Q30);
    beat_next.x = XW'(gain_prod[45:14]);
    // fold by a half turn; the result is negated at the back end
    if (z_raw > HALF_PI_Q30) begin
      beat_next.z    = z_raw - PI_Q30;
      beat_next.flip = 1'b1;
    end else if (z_raw < -HALF_PI_Q30) begin
      beat_next.z    = z_raw + PI_Q30;
      beat_next.flip = 1'b1;
    end else begin
      beat_next.z    = z_raw;
      beat_next.flip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_beat <= beat_next;
  end

endmodule

// File: hdl/epp_cordic.sv
// Rotation-mode CORDIC, one registered stage per iteration.
module epp_cordic import epp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  front_t in_beat,
  output logic   out_valid,
  output cord_t  out_beat
);

  logic                 vld  [0:RUN_STAGES];
  logic                 flip [0:RUN_STAGES];
  logic signed [ZW-1:0] zs   [0:RUN_STAGES];
  logic signed [XW-1:0] xs   [0:RUN_STAGES];
  logic signed [XW-1:0] ys   [0:RUN_STAGES];

  assign vld[0]  = in_valid;
  assign flip[0] = in_beat.flip;
  assign zs[0]   = in_beat.z;
  assign xs[0]   = in_beat.x;
  assign ys[0]   = '0;

  for (genvar i = 0; i < RUN_STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q30(i));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    // rotate toward zero residual angle; both updates use the old vector
    always_ff @(posedge clk) begin
      flip[i+1] <= flip[i];
      if (!zs[i][ZW-1]) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - ATAN;
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + ATAN;
      end
    end
  end

  assign out_valid     = vld[RUN_STAGES];
  assign out_beat.flip = flip[RUN_STAGES];
  assign out_beat.x    = xs[RUN_STAGES];
  assign out_beat.y    = ys[RUN_STAGES];

endmodule

// File: hdl/epp_scale.sv
// Axis scaler: undo the fold, then scale by half width and half height with rounding.
module epp_scale import epp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  cord_t       in_beat,
  input  logic [23:0] full_width,
  input  logic [23:0] full_height,
  output logic        out_valid,
  output point_t      out_beat
);

  localparam logic signed [59:0] ROUND_HALF = 60'sd4194304;

  logic                 fold_valid;
  logic signed [XW-1:0] cq;
  logic signed [XW-1:0] sq;
  logic signed [59:0]   prod_x;
  logic signed [59:0]   prod_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      fold_valid <= in_valid;
      out_valid  <= fold_valid;
    end
  end

  always_ff @(posedge clk) begin
    cq <= in_beat.flip ? -in_beat.x : in_beat.x;
    sq <= in_beat.flip ? -in_beat.y : in_beat.y;
  end

  always_comb begin
    prod_x = 60'(cq) * 60'($signed({1'b0, full_width}));
    prod_y = 60'(sq) * 60'($signed({1'b0, full_height}));
  end

  // the extra bit of shift takes half of the full size
  always_ff @(posedge clk) begin
    out_beat.px <= PW'((prod_x + ROUND_HALF) >>> 23);
    out_beat.py <= PW'((prod_y + ROUND_HALF) >>> 23);
  end

endmodule

// File: hdl/epp_place.sv
// Placement: rotate the scaled point, add the centre, round to Q16.8 and saturate.
module epp_place import epp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  point_t             in_beat,
  input  logic signed [23:0] center_x,
  input  logic signed [23:0] center_y,
  input  logic signed [15:0] rot_cos,
  input  logic signed [15:0] rot_sin,
  output logic               out_valid,
  output logic signed [23:0] proj_x,
  output logic signed [23:0] proj_y,
  output logic               saturated
);

  localparam logic signed [53:0] ROUND_HALF = 54'sd2097152;

  logic               prod_valid;
  logic signed [51:0] pxc;
  logic signed [51:0] pxs;
  logic signed [51:0] pyc;
  logic signed [51:0] pys;
  logic signed [53:0] ix;
  logic signed [53:0] iy;
  logic signed [31:0] rx;
  logic signed [31:0] ry;
  logic               sat_x;
  logic               sat_y;
  logic signed [23:0] ox;
  logic signed [23:0] oy;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    pxc <= 52'(in_beat.px) * 52'(rot_cos);
    pxs <= 52'(in_beat.px) * 52'(rot_sin);
    pyc <= 52'(in_beat.py) * 52'(rot_cos);
    pys <= 52'(in_beat.py) * 52'(rot_sin);
  end

  always_comb begin
    ix = 54'(pxc) - 54'(pys) + $signed({{8{center_x[23]}}, center_x, 22'b0}) + ROUND_HALF;
    iy = 54'(pxs) + 54'(pyc) + $signed({{8{center_y[23]}}, center_y, 22'b0}) + ROUND_HALF;
    rx = 32'(ix >>> 22);
    ry = 32'(iy >>> 22);
    sat_x = (rx > OUT_MAX) || (rx < OUT_MIN);
    sat_y = (ry > OUT_MAX) || (ry < OUT_MIN);
    if (rx > OUT_MAX) begin
      ox = 24'(OUT_MAX);
    end else if (rx < OUT_MIN) begin
      ox = 24'(OUT_MIN);
    end else begin
      ox = 24'(rx);
    end
    if (ry > OUT_MAX) begin
      oy = 24'(OUT_MAX);
    end else if (ry < OUT_MIN) begin
      oy = 24'(OUT_MIN);
    end else begin
      oy = 24'(ry);
    end
  end

  always_ff @(posedge clk) begin
    proj_x    <= ox;
    proj_y    <= oy;
    saturated <= sat_x || sat_y;
  end

endmodule

// File: hdl/ellipse_point_projector.sv
// Top level of the ellipse point projector: configuration registers and the point pipeline.
//
// Maps a polar point (angle in Q3.13 radians, radius in Q2.14 where 16384 lies
// on the curve) onto a rotated, shifted ellipse and returns the image point in
// Q16.8, clamped to 24 bits with a saturated flag. A request is taken on every
// clock edge where start is high; busy is always low, so a new point may be
// issued every cycle with no gaps. Each result shows up on proj_x, proj_y and
// saturated for one cycle, marked by done. A request passes through angle
// folding and gain correction, the 16 CORDIC iterations, the axis scaler (fold
// undo, then the width/height multiply) and placement (rotation multiplies,
// then centre add, rounding and clamping), each step registered. The receiver
// cannot stall the pipe, so results must be taken as they come. Configuration
// writes are registered; make them only while no request is in flight, since
// the later stages read the live registers. Writes to undefined indexes are
// dropped.
module ellipse_point_projector import epp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] polar_angle,
  input  logic [15:0]        polar_radius,
  output logic               done,
  output logic signed [23:0] proj_x,
  output logic signed [23:0] proj_y,
  output logic               saturated,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  logic signed [23:0] center_x;
  logic signed [23:0] center_y;
  logic [23:0]        full_width;
  logic [23:0]        full_height;
  logic signed [15:0] rot_cos;
  logic signed [15:0] rot_sin;

  logic   accept;
  logic   front_valid;
  front_t front_beat;
  logic   cord_valid;
  cord_t  cord_beat;
  logic   scale_valid;
  point_t scale_beat;

  // Never hold off a request: every stage advances every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_y    <= '0;
      full_width  <= 24'd256;
      full_height <= 24'd256;
      rot_cos     <= 16'sd16384;
      rot_sin     <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CENTER_X:    center_x    <= cfg_data;
        REG_CENTER_Y:    center_y    <= cfg_data;
        REG_FULL_WIDTH:  full_width  <= cfg_data;
        REG_FULL_HEIGHT: full_height <= cfg_data;
        REG_ROT_COS:     rot_cos     <= cfg_data[15:0];
        REG_ROT_SIN:     rot_sin     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Fold the angle, form the start radius
  epp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (accept),
    .polar_angle  (polar_angle),
    .polar_radius (polar_radius),
    .out_valid    (front_valid),
    .out_beat     (front_beat)
  );

  // Radius times cosine and sine
  epp_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_beat   (front_beat),
    .out_valid (cord_valid),
    .out_beat  (cord_beat)
  );

  // Scale by the half axes
  epp_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (cord_valid),
    .in_beat     (cord_beat),
    .full_width  (full_width),
    .full_height (full_height),
    .out_valid   (scale_valid),
    .out_beat    (scale_beat)
  );

  // Rotate, shift to the centre, round and saturate
  epp_place u_place (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (scale_valid),
    .in_beat   (scale_beat),
    .center_x  (center_x),
    .center_y  (center_y),
    .rot_cos   (rot_cos),
    .rot_sin   (rot_sin),
    .out_valid (done),
    .proj_x    (proj_x),
    .proj_y    (proj_y),
    .saturated (saturated)
  );

endmodule

// File: tb/tb_ellipse_point_projector.sv
// Testbench for the ellipse point projector: a directed table, then random points, checked cycle-free.
module tb_ellipse_point_projector;
  import epp_pkg::*;

  // Pipeline depth from request to done
  localparam int LATENCY     = RUN_STAGES + 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_DIR       = 41;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 210;

  // Spare register indexes: the block must drop writes to these
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  // Fixed-point constants of the datapath (Q30 radians, 1/K in Q30)
  localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
  localparam longint HALF_TURN_Q30    = 64'sd3373259426;
  localparam longint INV_GAIN_Q30     = 64'sd652032874;
  localparam longint COORD_HI         = 64'sd8388607;
  localparam longint COORD_LO         = -64'sd8388608;
  localparam int     ROT_STAGES       = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

  typedef struct packed {
    logic signed [15:0] ang;
    logic [15:0]        rad;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic               sat;
  } proj_point_t;

  typedef enum logic {ROW_POINT, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [2:0]         idx;
    logic [23:0]        data;
    logic signed [15:0] ang;
    logic [15:0]        rad;
    logic               typed;
    logic signed [23:0] want_x;
    logic signed [23:0] want_y;
    logic               want_sat;
  } stim_row_t;

  logic               clk;
  logic               rst          = 1'b1;
  logic               start        = 1'b0;
  logic               busy;
  logic signed [15:0] polar_angle  = '0;
  logic [15:0]        polar_radius = '0;
  logic               done;
  logic signed [23:0] proj_x;
  logic signed [23:0] proj_y;
  logic               saturated;
  logic               cfg_we       = 1'b0;
  logic [2:0]         cfg_index    = '0;
  logic [23:0]        cfg_data     = '0;

  // Shadow copy of the configuration registers, starting at reset values
  logic signed [23:0] center_x_q  = '0;
  logic signed [23:0] center_y_q  = '0;
  logic [23:0]        width_q     = 24'd256;
  logic [23:0]        height_q    = 24'd256;
  logic signed [15:0] rot_cos_q   = 16'sd16384;
  logic signed [15:0] rot_sin_q   = '0;

  // floor(atan(2^-i) * 2^30)
  longint atan_steps [0:23] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  proj_point_t pending_points [$];
  int          err_count   = 0;
  int          cycle_count = 0;
  int          idle_pct    = 0;

  ellipse_point_projector dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .polar_angle  (polar_angle),
    .polar_radius (polar_radius),
    .done         (done),
    .proj_x       (proj_x),
    .proj_y       (proj_y),
    .saturated    (saturated),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Print one line per mismatch and count every one
  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    err_count++;
  endtask

  // Work out the image of one polar point under the current shadow configuration
  function automatic proj_point_t project_point(input logic signed [15:0] ang,
                                                input logic [15:0] rad);
    proj_point_t r;
    longint z, x, y, dx, dy, px, py, ix, iy, ox, oy;
    longint wid, hgt, rc, rs, cx, cy;
    bit     fold;
    int     i;
    wid = longint'(width_q);
    hgt = longint'(height_q);
    rc  = longint'(rot_cos_q);
    rs  = longint'(rot_sin_q);
    cx  = longint'(center_x_q);
    cy  = longint'(center_y_q);
    // Fold the angle by a half turn into the CORDIC range; negate the vector later
    z    = longint'(ang);
    z    = z * 131072;
    fold = 1'b0;
    if (z > QUARTER_TURN_Q30) begin
      z    = z - HALF_TURN_Q30;
      fold = 1'b1;
    end else if (z < -QUARTER_TURN_Q30) begin
      z    = z + HALF_TURN_Q30;
      fold = 1'b1;
    end
    x = longint'(rad);
    x = (x * INV_GAIN_Q30) >>> 14;
    y = 0;
    for (i = 0; i < ROT_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_steps[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_steps[i];
      end
    end
    if (fold) begin
      x = -x;
      y = -y;
    end
    // Scale by half the axes, rotate, shift to the centre, round to Q16.8 and clamp
    px = (x * wid + 64'sd4194304) >>> 23;
    py = (y * hgt + 64'sd4194304) >>> 23;
    ix = px * rc - py * rs + cx * 64'sd4194304;
    iy = px * rs + py * rc + cy * 64'sd4194304;
    ox = (ix + 64'sd2097152) >>> 22;
    oy = (iy + 64'sd2097152) >>> 22;
    r.sat = 1'b0;
    if (ox > COORD_HI) begin
      ox    = COORD_HI;
      r.sat = 1'b1;
    end else if (ox < COORD_LO) begin
      ox    = COORD_LO;
      r.sat = 1'b1;
    end
    if (oy > COORD_HI) begin
      oy    = COORD_HI;
      r.sat = 1'b1;
    end else if (oy < COORD_LO) begin
      oy    = COORD_LO;
      r.sat = 1'b1;
    end
    r.x   = ox[23:0];
    r.y   = oy[23:0];
    r.ang = ang;
    r.rad = rad;
    return r;
  endfunction

  // Table row builders: a point checked by the predictor, a point with a typed
  // result, and a register write
  function automatic stim_row_t pt(input logic signed [15:0] ang, input logic [15:0] rad);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_POINT;
    r.ang   = ang;
    r.rad   = rad;
    return r;
  endfunction

  function automatic stim_row_t pt_at(input logic signed [15:0] ang, input logic [15:0] rad,
                                      input logic [23:0] wx, input logic [23:0] wy,
                                      input logic ws);
    stim_row_t r;
    r          = pt(ang, rad);
    r.typed    = 1'b1;
    r.want_x   = wx;
    r.want_y   = wy;
    r.want_sat = ws;
    return r;
  endfunction

  function automatic stim_row_t wr(input logic [2:0] idx, input logic [23:0] data);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  // Pick a register value: a moderate one, an extreme or raw bits
  function automatic logic [23:0] pick_reg_value(input logic [2:0] idx);
    int v;
    v = 0;
    case (idx)
      REG_CENTER_X, REG_CENTER_Y: begin
        case ($urandom_range(4))
          0:       v = 32'h007FFFFF;
          1:       v = 32'h00800000;
          2:       v = $urandom;
          default: v = int'($urandom_range(0, 65536)) - 32768;
        endcase
      end
      REG_FULL_WIDTH, REG_FULL_HEIGHT: begin
        case ($urandom_range(4))
          0:       v = 0;
          1:       v = 32'h00FFFFFF;
          2:       v = $urandom;
          default: v = $urandom_range(1, 65536);
        endcase
      end
      default: begin
        // Rotation terms: upper data bits are don't-care, off-circle values allowed
        case ($urandom_range(4))
          0:       v = 16384;
          1:       v = -16384;
          2:       v = $urandom;
          default: v = int'($urandom_range(0, 32768)) - 16384;
        endcase
      end
    endcase
    return v[23:0];
  endfunction

  // Write one register and mirror it in the shadow copy; unknown indexes are dropped
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CENTER_X:    center_x_q = data;
      REG_CENTER_Y:    center_y_q = data;
      REG_FULL_WIDTH:  width_q    = data;
      REG_FULL_HEIGHT: height_q   = data;
      REG_ROT_COS:     rot_cos_q  = data[15:0];
      REG_ROT_SIN:     rot_sin_q  = data[15:0];
      default:         ;
    endcase
    @(posedge clk);
  endtask

  // Drop start and hold until every request in flight has come back
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Issue one request, sometimes after a random gap; record its expected result on acceptance
  task automatic send_point(input logic signed [15:0] ang, input logic [15:0] rad,
                            input logic use_given, input proj_point_t given);
    proj_point_t want;
    want     = use_given ? given : project_point(ang, rad);
    want.ang = ang;
    want.rad = rad;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start        <= 1'b1;
    polar_angle  <= ang;
    polar_radius <= rad;
    do @(posedge clk); while (busy === 1'b1);
    pending_points.push_back(want);
  endtask

  // Compare every strobed result with the oldest pending expectation
  always @(posedge clk) begin : result_check
    proj_point_t want;
    if (!rst && done !== 1'b0) begin
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("unexpected result x=%0d y=%0d sat=%b",
                                  proj_x, proj_y, saturated));
      end else begin
        want = pending_points.pop_front();
        if (proj_x !== want.x)
          report_mismatch($sformatf("proj_x ang=%0d rad=%0d got %0d want %0d",
                                    want.ang, want.rad, proj_x, want.x));
        if (proj_y !== want.y)
          report_mismatch($sformatf("proj_y ang=%0d rad=%0d got %0d want %0d",
                                    want.ang, want.rad, proj_y, want.y));
        if (saturated !== want.sat)
          report_mismatch($sformatf("saturated ang=%0d rad=%0d got %b want %b",
                                    want.ang, want.rad, saturated, want.sat));
      end
    end
  end

  // Stop a hung run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    stim_row_t          dir_rows [0:N_DIR-1];
    proj_point_t        given;
    logic signed [15:0] ang;
    logic [15:0]        rad;
    int                 ph, n, ri;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    dir_rows = '{
      // Reset configuration: half-unit ellipse at the origin, no rotation
      pt_at(0, 0, 24'h000000, 24'h000000, 1'b0),
      pt(0, 16384),
      pt(12867, 16384),                       // just inside a quarter turn
      pt(12868, 16384),                       // just past it: folded
      pt(-12867, 16384),
      pt(-12868, 16384),
      pt(25736, 16384),                       // near plus pi
      pt(-25736, 16384),                      // near minus pi
      pt(32767, 65535),                       // angle code extremes, full radius
      pt(-32768, 65535),
      pt(6434, 65535),
      // Centre at the corners of the range: any outward step clamps
      wr(REG_CENTER_X, 24'h7FFFFF),
      wr(REG_CENTER_Y, 24'h800000),
      pt_at(0, 0, 24'h7FFFFF, 24'h800000, 1'b0),
      pt(0, 16384),
      pt(-12868, 65535),
      // Widest axes and a negated cosine term
      wr(REG_FULL_WIDTH, 24'hFFFFFF),
      wr(REG_FULL_HEIGHT, 24'hFFFFFF),
      wr(REG_ROT_COS, 24'hFFC000),
      wr(REG_ROT_SIN, 24'h004000),
      pt(6434, 65535),
      pt(-19302, 65535),
      // Rotation terms off the unit circle; upper data bits must be ignored
      wr(REG_ROT_COS, 24'h007FFF),
      wr(REG_ROT_SIN, 24'hFF8000),
      pt(3217, 40000),
      pt(-3217, 65535),
      // Spare indexes must not disturb the centre
      wr(REG_CENTER_X, 24'h000000),
      wr(REG_CENTER_Y, 24'h000000),
      wr(REG_SPARE_A, 24'h123456),
      wr(REG_SPARE_B, 24'hABCDEF),
      pt_at(0, 0, 24'h000000, 24'h000000, 1'b0),
      // Zero axes collapse every point onto the centre
      wr(REG_FULL_WIDTH, 24'h000000),
      wr(REG_FULL_HEIGHT, 24'h000000),
      pt_at(8000, 65535, 24'h000000, 24'h000000, 1'b0),
      pt_at(-32768, 65535, 24'h000000, 24'h000000, 1'b0),
      wr(REG_FULL_WIDTH, 24'd256),
      wr(REG_FULL_HEIGHT, 24'd256),
      wr(REG_ROT_COS, 24'h004000),
      wr(REG_ROT_SIN, 24'h000000),
      pt(1, 1),
      pt(-1, 16383)
    };

    // Walk the directed table; writes wait for the pipe to drain
    idle_pct = 26;
    for (n = 0; n < N_DIR; n++) begin
      if (dir_rows[n].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(dir_rows[n].idx, dir_rows[n].data);
      end else begin
        given     = '0;
        given.x   = dir_rows[n].want_x;
        given.y   = dir_rows[n].want_y;
        given.sat = dir_rows[n].want_sat;
        send_point(dir_rows[n].ang, dir_rows[n].rad, dir_rows[n].typed, given);
      end
    end

    // Random phases: reconfigure while idle, then stream points. Sender gaps
    // go from light to heavy to none so the pipe also runs back to back.
    for (ph = 0; ph < N_PHASES; ph++) begin
      idle_pct = (ph < 3) ? 26 : (ph < 6) ? 85 : 0;
      wait_idle();
      case (ph)
        1: begin
          write_reg(REG_CENTER_X, 24'h7FFFFF);
          write_reg(REG_CENTER_Y, 24'h7FFFFF);
          write_reg(REG_FULL_WIDTH, 24'hFFFFFF);
          write_reg(REG_FULL_HEIGHT, 24'hFFFFFF);
          write_reg(REG_ROT_COS, 24'h004000);
          write_reg(REG_ROT_SIN, 24'h007FFF);
        end
        2: begin
          write_reg(REG_CENTER_X, 24'h800000);
          write_reg(REG_CENTER_Y, 24'h800000);
          write_reg(REG_FULL_WIDTH, 24'h000001);
          write_reg(REG_FULL_HEIGHT, 24'h000001);
          write_reg(REG_ROT_COS, 24'hFFC000);
          write_reg(REG_ROT_SIN, 24'h008000);
        end
        default: begin
          for (ri = 0; ri < 6; ri++) begin
            if (ph == 0 || $urandom_range(2) != 0)
              write_reg(3'(ri), pick_reg_value(3'(ri)));
          end
          if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, 24'($urandom));
        end
      endcase

      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Angle: mostly the documented range, some raw codes, some near the folds
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: ang = 16'(int'($urandom_range(0, 51472)) - 25736);
          6, 7:             ang = 16'($urandom);
          8:                ang = 16'(($urandom_range(1) ? 12868 : -12868)
                                      + int'($urandom_range(0, 6)) - 3);
          default:          ang = 16'(($urandom_range(1) ? 25736 : -25736)
                                      + int'($urandom_range(0, 6)) - 3);
        endcase
        // Radius: raw codes, near the curve, the ends, and small values
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: rad = 16'($urandom);
          6, 7:             rad = 16'(16384 + int'($urandom_range(0, 64)) - 32);
          8:                rad = $urandom_range(1) ? 16'd0 : 16'hFFFF;
          default:          rad = 16'($urandom_range(0, 255));
        endcase
        send_point(ang, rad, 1'b0, '0);
      end
    end

    // Drain the pipe, then give any stray result time to show up
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
